>>> src/tlv_record_store_engine_unit_defines.svh
// Assertion macros for the record store engine.
`ifndef TLV_RECORD_STORE_ENGINE_UNIT_DEFINES_SVH
`define TLV_RECORD_STORE_ENGINE_UNIT_DEFINES_SVH
// Checked at every edge outside reset.
`define TLV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define TLV_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> src/tlv_pkg.sv
// Request codes, status codes and record format constants of the record store engine.
package tlv_pkg;
  localparam logic [2:0] REQ_RAW_WR = 3'd0;
  localparam logic [2:0] REQ_RAW_RD = 3'd1;
  localparam logic [2:0] REQ_GET    = 3'd2;
  localparam logic [2:0] REQ_UPDATE = 3'd3;
  localparam logic [2:0] REQ_DELETE = 3'd4;
  localparam logic [2:0] REQ_ADD    = 3'd5;
  localparam logic [2:0] REQ_CHECK  = 3'd6;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [7:0] DELETED_TAG = 8'hFF;
  localparam logic [7:0] MAX_COUNT   = 8'd250;
  localparam logic [7:0] HVT_RESET   = 8'd250;
endpackage

>>> src/tlv_record_store_engine_unit.sv
// Top level of the record store engine: byte store, chain walker and checksum writer.
// The sequencer serves a request by walking the record chain through the
// single-port-read byte store one byte per cycle. Every request ends with the checksum
// walk; raw access does its read or write before it. Get, update, delete and add first
// run a search, and add may search twice (the second time for a deleted slot), followed
// by a read or a modify of the record. The worst case is an add on a store packed with
// zero-length records.
// busy is high from the accepting edge until the result; the result appears on
// out_* for one cycle with out_valid high and cannot be held off, so it must be taken
// then. A new request may be started in the cycle that the result is shown. The store
// holds no reset value: records must be written (raw write) before they are used.
`include "tlv_record_store_engine_unit_defines.svh"
module tlv_record_store_engine_unit #(
  parameter int STORE_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_raw_address,
  input  logic [7:0] in_tag,
  input  logic [7:0] in_length,
  input  logic [7:0] in_value_offset,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  output logic [7:0] out_read_data,
  output logic [1:0] out_status,
  output logic       out_format_error,
  output logic [8:0] out_image_size,
  output logic [7:0] out_checksum_byte,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import tlv_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  // pointer width: holds p + 2 + 255 without wrap
  localparam int PW = ((AW > 8) ? AW : 8) + 2;
  localparam logic [PW-1:0] STORE_P = PW'(STORE_BYTES);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_RAW    = 16'h0002,
    S_RAWD   = 16'h0004,
    S_F_CNT  = 16'h0008,
    S_F_CNTD = 16'h0010,
    S_F_CHK  = 16'h0020,
    S_F_TAG  = 16'h0040,
    S_F_LEN  = 16'h0080,
    S_F_MISS = 16'h0100,
    S_MOD    = 16'h0200,
    S_MOD2   = 16'h0400,
    S_GETD   = 16'h0800,
    S_W_B0   = 16'h1000,
    S_W_B1   = 16'h2000,
    S_W_CNT  = 16'h4000,
    S_W_LOOP = 16'h8000
  } state_t;

  // walk sub-steps share S_W_LOOP
  typedef enum logic [4:0] {
    W_CHK = 5'b00001,
    W_TAG = 5'b00010,
    W_LEN = 5'b00100,
    W_VAL = 5'b01000,
    W_END = 5'b10000
  } wstep_t;

  // byte store
  logic [7:0] mem [STORE_BYTES];
  logic [7:0] mem_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [7:0]    mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  state_t state_r, state_nxt;
  wstep_t wstep_r, wstep_nxt;
  logic [2:0]    req_r, req_nxt;
  logic [7:0]    addr_r, addr_nxt, tag_r, tag_nxt, len_r, len_nxt;
  logic [7:0]    off_r, off_nxt, data_r, data_nxt, srch_r, srch_nxt;
  logic [7:0]    hvt_r, hvt_nxt;
  logic          err_seen_r, err_seen_nxt;
  logic [7:0]    cnt_r, cnt_nxt, i_r, i_nxt, l_r, l_nxt, rem_r, rem_nxt;
  logic [7:0]    sum_r, sum_nxt, b0_r, b0_nxt;
  logic [PW-1:0] p_r, p_nxt, va_r, va_nxt, pos_r, pos_nxt;
  logic          werr_r, werr_nxt, pass2_r, pass2_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [7:0]    rdata_r, rdata_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    ord_r, ord_nxt, ochk_r, ochk_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic          oerr_r, oerr_nxt;
  logic [8:0]    osize_r, osize_nxt;

  logic [PW-1:0] addr_ext, vb, rec_end, size_w;
  logic          addr_ok, commit, req_ok, over_w, err_w;

  assign addr_ext = PW'(addr_r);
  assign addr_ok  = addr_ext < STORE_P;
  assign vb       = pos_r + PW'(2) + PW'(off_r);
  assign rec_end  = p_r + PW'(2) + PW'(mem_q);
  assign commit   = (req_r != REQ_RAW_WR) && (req_r != REQ_RAW_RD) && (req_r != REQ_UNUSED);
  assign req_ok   = (in_tag != DELETED_TAG) &&
                    ((in_req_type == REQ_DELETE) || (in_value_offset < in_length));
  // end of walk
  assign over_w   = ov_r || (p_r >= STORE_P);
  assign err_w    = werr_r || over_w;
  assign size_w   = over_w ? STORE_P : (p_r + PW'(1));

  always_comb begin
    state_nxt = state_r; wstep_nxt = wstep_r;
    req_nxt = req_r; addr_nxt = addr_r; tag_nxt = tag_r; len_nxt = len_r;
    off_nxt = off_r; data_nxt = data_r; srch_nxt = srch_r;
    hvt_nxt = cfg_we ? cfg_wdata : hvt_r;
    err_seen_nxt = err_seen_r;
    cnt_nxt = cnt_r; i_nxt = i_r; l_nxt = l_r; rem_nxt = rem_r;
    sum_nxt = sum_r; b0_nxt = b0_r; p_nxt = p_r; va_nxt = va_r; pos_nxt = pos_r;
    werr_nxt = werr_r; pass2_nxt = pass2_r; status_nxt = status_r; rdata_nxt = rdata_r;
    ov_nxt = ov_r;
    ord_nxt = ord_r; ochk_nxt = ochk_r; ost_nxt = ost_r; oerr_nxt = oerr_r;
    osize_nxt = osize_r;
    mem_re = 1'b0; mem_raddr = '0; mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req_type; addr_nxt = in_raw_address; tag_nxt = in_tag;
          len_nxt = in_length; off_nxt = in_value_offset; data_nxt = in_data_byte;
          srch_nxt = in_tag; pass2_nxt = 1'b0; rdata_nxt = '0; status_nxt = ST_OK;
          priority if (in_req_type == REQ_RAW_WR || in_req_type == REQ_RAW_RD ||
                       in_req_type == REQ_UNUSED) begin
            status_nxt = (in_req_type == REQ_UNUSED) ? ST_MISS : ST_OK;
            state_nxt = S_RAW;
          end else if (in_req_type == REQ_CHECK) begin
            state_nxt = S_W_B0;
          end else if (!req_ok) begin
            status_nxt = ST_MISS;
            state_nxt = S_W_B0;
          end else begin
            state_nxt = S_F_CNT;
          end
        end
      end
      S_RAW: begin
        if (req_r == REQ_RAW_WR && addr_ok) begin
          mem_we = 1'b1; mem_waddr = addr_ext[AW-1:0]; mem_wdata = data_r;
        end
        mem_re = 1'b1; mem_raddr = addr_ext[AW-1:0];
        state_nxt = S_RAWD;
      end
      S_RAWD: begin
        if (req_r == REQ_RAW_RD && addr_ok) rdata_nxt = mem_q;
        state_nxt = S_W_B0;
      end
      S_F_CNT: begin
        mem_re = 1'b1; mem_raddr = AW'(1);
        state_nxt = S_F_CNTD;
      end
      S_F_CNTD: begin
        cnt_nxt = mem_q; p_nxt = PW'(2); i_nxt = '0;
        state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        if (i_r >= cnt_r || p_r + PW'(1) >= STORE_P) begin
          state_nxt = S_F_MISS;
        end else begin
          mem_re = 1'b1; mem_raddr = p_r[AW-1:0];
          state_nxt = S_F_TAG;
        end
      end
      S_F_TAG: begin
        l_nxt = mem_q;   // tag held here until length arrives
        mem_re = 1'b1; mem_raddr = AW'(p_r + PW'(1));
        state_nxt = S_F_LEN;
      end
      S_F_LEN: begin
        priority if (rec_end > STORE_P) begin
          state_nxt = S_F_MISS;
        end else if (l_r == srch_r && mem_q == len_r) begin
          pos_nxt = p_r;
          state_nxt = S_MOD;
        end else begin
          p_nxt = rec_end; i_nxt = i_r + 8'd1;
          state_nxt = S_F_CHK;
        end
      end
      S_F_MISS: begin
        if (req_r == REQ_ADD && !pass2_r) begin
          pass2_nxt = 1'b1; srch_nxt = DELETED_TAG; p_nxt = PW'(2); i_nxt = '0;
          state_nxt = S_F_CHK;
        end else begin
          status_nxt = ST_MISS;
          state_nxt = S_W_B0;
        end
      end
      S_MOD: begin
        priority if (req_r == REQ_GET) begin
          mem_re = 1'b1; mem_raddr = vb[AW-1:0];
          state_nxt = S_GETD;
        end else if (req_r == REQ_DELETE) begin
          mem_we = 1'b1; mem_waddr = pos_r[AW-1:0]; mem_wdata = DELETED_TAG;
          state_nxt = S_W_B0;
        end else if (pass2_r) begin
          // reuse of a deleted slot: tag first, value byte next
          mem_we = 1'b1; mem_waddr = pos_r[AW-1:0]; mem_wdata = tag_r;
          state_nxt = S_MOD2;
        end else begin
          state_nxt = S_MOD2;
        end
      end
      S_MOD2: begin
        if (vb < STORE_P) begin
          mem_we = 1'b1; mem_waddr = vb[AW-1:0]; mem_wdata = data_r;
        end
        state_nxt = S_W_B0;
      end
      S_GETD: begin
        rdata_nxt = mem_q;
        state_nxt = S_W_B0;
      end
      S_W_B0: begin
        mem_re = 1'b1; mem_raddr = '0;
        state_nxt = S_W_B1;
      end
      S_W_B1: begin
        b0_nxt = mem_q;
        mem_re = 1'b1; mem_raddr = AW'(1);
        state_nxt = S_W_CNT;
      end
      S_W_CNT: begin
        cnt_nxt = mem_q; sum_nxt = b0_r + mem_q;
        werr_nxt = (mem_q == 8'd0) || (mem_q > MAX_COUNT);
        p_nxt = PW'(2); i_nxt = '0; ov_nxt = 1'b0;
        wstep_nxt = W_CHK;
        state_nxt = S_W_LOOP;
      end
      S_W_LOOP: begin
        unique case (wstep_r)
          W_CHK: begin
            priority if (i_r >= cnt_r) begin
              wstep_nxt = W_END;
            end else if (p_r + PW'(1) >= STORE_P) begin
              ov_nxt = 1'b1; wstep_nxt = W_END;
            end else begin
              mem_re = 1'b1; mem_raddr = p_r[AW-1:0];
              wstep_nxt = W_TAG;
            end
          end
          W_TAG: begin
            if (mem_q > hvt_r && mem_q != DELETED_TAG) werr_nxt = 1'b1;
            sum_nxt = sum_r + mem_q;
            mem_re = 1'b1; mem_raddr = AW'(p_r + PW'(1));
            wstep_nxt = W_LEN;
          end
          W_LEN: begin
            if (mem_q == 8'd0) werr_nxt = 1'b1;
            sum_nxt = sum_r + mem_q;
            l_nxt = mem_q;
            priority if (rec_end > STORE_P) begin
              ov_nxt = 1'b1; wstep_nxt = W_END;
            end else if (mem_q == 8'd0) begin
              p_nxt = rec_end; i_nxt = i_r + 8'd1; wstep_nxt = W_CHK;
            end else begin
              mem_re = 1'b1; mem_raddr = AW'(p_r + PW'(2));
              va_nxt = p_r + PW'(3); rem_nxt = mem_q;
              wstep_nxt = W_VAL;
            end
          end
          W_VAL: begin
            sum_nxt = sum_r + mem_q;
            if (rem_r == 8'd1) begin
              p_nxt = p_r + PW'(2) + PW'(l_r); i_nxt = i_r + 8'd1; wstep_nxt = W_CHK;
            end else begin
              mem_re = 1'b1; mem_raddr = va_r[AW-1:0];
              va_nxt = va_r + PW'(1); rem_nxt = rem_r - 8'd1;
            end
          end
          W_END: begin
            ochk_nxt = '0;
            if (commit && !over_w) begin
              mem_we = 1'b1; mem_waddr = p_r[AW-1:0]; mem_wdata = sum_r;
              ochk_nxt = sum_r;
            end
            if (commit) err_seen_nxt = err_w;
            oerr_nxt = commit ? err_w : err_seen_r;
            ost_nxt = (req_r == REQ_CHECK) ?
                      ((b0_r != 8'd0 || err_w) ? ST_INVALID : ST_OK) : status_r;
            osize_nxt = (size_w > PW'(511)) ? 9'd511 : size_w[8:0];
            ord_nxt = rdata_r;
            ov_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
          default: wstep_nxt = W_CHK;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; wstep_r <= W_CHK; hvt_r <= HVT_RESET;
      err_seen_r <= 1'b0; out_valid_r <= 1'b0; ov_r <= 1'b0; pass2_r <= 1'b0;
    end else begin
      state_r <= state_nxt; wstep_r <= wstep_nxt; hvt_r <= hvt_nxt;
      err_seen_r <= err_seen_nxt; ov_r <= ov_nxt; pass2_r <= pass2_nxt;
      out_valid_r <= (state_r == S_W_LOOP) && (wstep_r == W_END);
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; addr_r <= addr_nxt; tag_r <= tag_nxt; len_r <= len_nxt;
    off_r <= off_nxt; data_r <= data_nxt; srch_r <= srch_nxt;
    cnt_r <= cnt_nxt; i_r <= i_nxt; l_r <= l_nxt; rem_r <= rem_nxt;
    sum_r <= sum_nxt; b0_r <= b0_nxt; p_r <= p_nxt; va_r <= va_nxt; pos_r <= pos_nxt;
    werr_r <= werr_nxt; status_r <= status_nxt; rdata_r <= rdata_nxt;
    ord_r <= ord_nxt; ochk_r <= ochk_nxt; ost_r <= ost_nxt; oerr_r <= oerr_nxt;
    osize_r <= osize_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_read_data     = ord_r;
  assign out_status        = ost_r;
  assign out_format_error  = oerr_r;
  assign out_image_size    = osize_r;
  assign out_checksum_byte = ochk_r;

  `TLV_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
  `TLV_ASSERT(a_result_idle, out_valid |-> !busy || $past(start), "result while still busy")
  `TLV_ASSERT(a_single_pulse, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `TLV_ASSERT(a_invalid_check, (out_valid && out_status == ST_INVALID) |-> req_r == REQ_CHECK,
    "image invalid reported for a request other than check")
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the TLV record store engine.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tlv_pkg::*;

  localparam int MEM_BYTES = 256;
  localparam int ITEM_GOAL = 1550;

  // one request as driven on the in_* ports
  typedef struct {
    logic [2:0] req;
    logic [7:0] addr;
    logic [7:0] tag;
    logic [7:0] len;
    logic [7:0] off;
    logic [7:0] data;
  } req_t;

  // one response as seen on the out_* ports
  typedef struct {
    logic [7:0] rdata;
    logic [1:0] status;
    logic       ferr;
    logic [8:0] size;
    logic [7:0] chk;
  } resp_t;

  // directed row: request plus an optional hand-typed status
  typedef struct {
    logic [2:0] req;
    logic [7:0] tag;
    logic [7:0] len;
    logic [7:0] off;
    logic [7:0] addr;
    logic [7:0] data;
    bit         has_st;
    logic [1:0] st;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_req_type = '0;
  logic [7:0] in_raw_address = '0;
  logic [7:0] in_tag = '0;
  logic [7:0] in_length = 8'd1;
  logic [7:0] in_value_offset = '0;
  logic [7:0] in_data_byte = '0;
  logic       out_valid;
  logic [7:0] out_read_data;
  logic [1:0] out_status;
  logic       out_format_error;
  logic [8:0] out_image_size;
  logic [7:0] out_checksum_byte;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  tlv_record_store_engine_unit #(.STORE_BYTES(MEM_BYTES)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_raw_address(in_raw_address), .in_tag(in_tag),
    .in_length(in_length), .in_value_offset(in_value_offset),
    .in_data_byte(in_data_byte), .out_valid(out_valid), .out_read_data(out_read_data),
    .out_status(out_status), .out_format_error(out_format_error),
    .out_image_size(out_image_size), .out_checksum_byte(out_checksum_byte),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // generous cap: worst case is far below this
  initial begin
    #200ms;
    $display("FAIL tlv_record_store_engine_unit");
    $finish;
  end

  // shadow copy of the block's state
  logic [7:0] img_mem [MEM_BYTES];
  bit         err_flag;
  logic [7:0] max_tag;

  resp_t      resp_q[$];
  int         n_err;
  int         n_items;
  int         burst_left;

  // chain walk: returns image size, flags format errors, optionally commits checksum
  function automatic void chain_walk(input bit commit, output bit err,
                                     output logic [8:0] size, output logic [7:0] chk);
    int sum, cnt, p, t, l;
    bit over;
    sum = img_mem[0] + img_mem[1];
    cnt = img_mem[1];
    p = 2;
    over = 0;
    err = (cnt == 0) || (cnt > MAX_COUNT);
    for (int i = 0; i < cnt; i++) begin
      if (p + 1 >= MEM_BYTES) begin
        over = 1;
        break;
      end
      t = img_mem[p];
      l = img_mem[p+1];
      if (l == 0) err = 1;
      if (t > max_tag && t != DELETED_TAG) err = 1;
      sum += t + l;
      if (p + 2 + l > MEM_BYTES) begin
        over = 1;
        break;
      end
      for (int k = 0; k < l; k++) sum += img_mem[p+2+k];
      p += 2 + l;
    end
    if (!over && p >= MEM_BYTES) over = 1;
    chk = '0;
    if (over) begin
      err = 1;
      p = MEM_BYTES;
    end else begin
      if (commit) begin
        img_mem[p] = sum[7:0];
        chk = sum[7:0];
      end
      p += 1;
    end
    size = p[8:0];
  endfunction

  // position of the first complete record matching tag and length, -1 if none
  function automatic int rec_find(input int want_tag, input int want_len);
    int p, t, l;
    p = 2;
    for (int i = 0; i < img_mem[1]; i++) begin
      if (p + 1 >= MEM_BYTES) break;
      t = img_mem[p];
      l = img_mem[p+1];
      if (p + 2 + l > MEM_BYTES) break;
      if (t == want_tag && l == want_len) return p;
      p += 2 + l;
    end
    return -1;
  endfunction

  // applies one request to the shadow state and returns the response it should give
  function automatic resp_t store_apply(input req_t r);
    resp_t o;
    bit    ok, e;
    int    pos, vb;
    o = '{default: '0};
    if (r.req == REQ_RAW_WR || r.req == REQ_RAW_RD) begin
      if (r.req == REQ_RAW_WR) img_mem[r.addr] = r.data;
      else o.rdata = img_mem[r.addr];
      chain_walk(0, e, o.size, o.chk);
      o.chk = '0;
      o.ferr = err_flag;
    end else begin
      if (r.req != REQ_CHECK) begin
        ok = (r.tag != DELETED_TAG) && (r.req == REQ_DELETE || r.off < r.len);
        pos = ok ? rec_find(r.tag, r.len) : -1;
        if (ok && pos < 0 && r.req == REQ_ADD) begin
          pos = rec_find(DELETED_TAG, r.len);
          if (pos >= 0) img_mem[pos] = r.tag;
        end
        if (pos < 0) begin
          o.status = ST_MISS;
        end else begin
          vb = pos + 2 + r.off;
          if (r.req == REQ_GET) o.rdata = (vb < MEM_BYTES) ? img_mem[vb] : 8'h00;
          else if (r.req == REQ_DELETE) img_mem[pos] = DELETED_TAG;
          else if (vb < MEM_BYTES) img_mem[vb] = r.data;
        end
      end
      chain_walk(1, e, o.size, o.chk);
      err_flag = e;
      o.ferr = e;
      if (r.req == REQ_CHECK) o.status = (img_mem[0] != 0 || e) ? ST_INVALID : ST_OK;
    end
    return o;
  endfunction

  task automatic report(input string what, input logic [8:0] got, input logic [8:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_err++;
  endtask

  // response checker: out_* is valid for exactly one cycle
  always @(posedge clk) begin
    resp_t w;
    if (rst_n && out_valid) begin
      if (resp_q.size() == 0) begin
        report("unexpected response", 9'd1, 9'd0);
      end else begin
        w = resp_q.pop_front();
        if (out_read_data !== w.rdata)
          report("read_data", 9'(out_read_data), 9'(w.rdata));
        if (out_status !== w.status)
          report("status", 9'(out_status), 9'(w.status));
        if (out_format_error !== w.ferr)
          report("format_error", 9'(out_format_error), 9'(w.ferr));
        if (out_image_size !== w.size)
          report("image_size", out_image_size, w.size);
        if (out_checksum_byte !== w.chk)
          report("checksum_byte", 9'(out_checksum_byte), 9'(w.chk));
      end
    end
  end

  // drives one request, holds it until accepted, then queues its prediction;
  // has_st and st override the predicted status for hand-checked rows
  task automatic issue(input req_t r, input bit has_st = 0, input logic [1:0] st = ST_OK);
    resp_t o;
    start <= 1'b1;
    in_req_type <= r.req;
    in_raw_address <= r.addr;
    in_tag <= r.tag;
    in_length <= r.len;
    in_value_offset <= r.off;
    in_data_byte <= r.data;
    do @(posedge clk); while (busy);
    o = store_apply(r);
    if (has_st) o.status = st;
    resp_q.push_back(o);
    n_items++;
    // sender bursts with random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  endtask

  task automatic raw_wr(input int a, input int d);
    req_t r;
    r = '{req: REQ_RAW_WR, addr: a[7:0], tag: 8'd0, len: 8'd1, off: 8'd0, data: d[7:0]};
    issue(r);
  endtask

  // waits until every response is in and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (resp_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_max_tag(input logic [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    max_tag = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // builds a record image with raw writes; returns its tag/length pairs
  task automatic build_image(output int tags[$], output int lens[$]);
    int n, p, l, t, big;
    tags.delete();
    lens.delete();
    big = ($urandom_range(0, 9) == 0);
    n = big ? $urandom_range(6, 40) : $urandom_range(1, 5);
    p = 2;
    raw_wr(0, ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) l = $urandom_range(1, 250);
      else l = $urandom_range(1, big ? 5 : 8);
      if (p + 2 + l >= MEM_BYTES && $urandom_range(0, 3) != 0) break;
      if (p + 1 >= MEM_BYTES) break;
      case ($urandom_range(0, 9))
        0: t = DELETED_TAG;
        1: t = $urandom_range(0, 254);
        default: t = $urandom_range(0, max_tag);
      endcase
      raw_wr(p, t);
      raw_wr(p + 1, ($urandom_range(0, 39) == 0) ? 0 : l);
      tags.push_back(t);
      lens.push_back(l);
      for (int k = 0; k < l && p + 2 + k < MEM_BYTES; k++) begin
        if ($urandom_range(0, 1) == 0) raw_wr(p + 2 + k, $urandom_range(0, 255));
      end
      p += 2 + l;
    end
    case ($urandom_range(0, 19))
      0: raw_wr(1, 0);
      1: raw_wr(1, $urandom_range(251, 255));
      2: raw_wr(1, $urandom_range(1, 250));
      default: raw_wr(1, tags.size() == 0 ? 1 : tags.size());
    endcase
  endtask

  // directed rows on a small known image:
  // byte 0 type, byte 1 count 2, record tag 5 len 3, record tag 250 len 1
  dir_row_t dir_tab [21] = '{
    '{REQ_CHECK,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1, ST_OK},
    '{REQ_GET,    8'd5,   8'd3,   8'd0,   8'd0,   8'd0,   1, ST_OK},
    '{REQ_GET,    8'd5,   8'd3,   8'd2,   8'd0,   8'd0,   1, ST_OK},
    '{REQ_GET,    8'd5,   8'd3,   8'd3,   8'd0,   8'd0,   1, ST_MISS},  // offset past value
    '{REQ_GET,    8'd255, 8'd3,   8'd0,   8'd0,   8'd0,   1, ST_MISS},  // reserved tag
    '{REQ_UPDATE, 8'd5,   8'd3,   8'd1,   8'd0,   8'hFF,  1, ST_OK},
    '{REQ_GET,    8'd250, 8'd1,   8'd0,   8'd0,   8'd0,   1, ST_OK},
    '{REQ_DELETE, 8'd5,   8'd3,   8'd0,   8'd0,   8'd0,   1, ST_OK},
    '{REQ_GET,    8'd5,   8'd3,   8'd0,   8'd0,   8'd0,   1, ST_MISS},
    '{REQ_ADD,    8'd7,   8'd3,   8'd2,   8'd0,   8'h00,  1, ST_OK},    // reuses deleted slot
    '{REQ_ADD,    8'd9,   8'd2,   8'd0,   8'd0,   8'h5A,  1, ST_MISS},  // no free slot
    '{REQ_GET,    8'd7,   8'd250, 8'd249, 8'd0,   8'd0,   1, ST_MISS},
    '{REQ_UPDATE, 8'd0,   8'd1,   8'd0,   8'd0,   8'd0,   1, ST_MISS},
    '{REQ_RAW_RD, 8'd0,   8'd1,   8'd0,   8'd255, 8'd0,   1, ST_OK},
    '{REQ_RAW_RD, 8'd0,   8'd1,   8'd0,   8'd0,   8'd0,   1, ST_OK},
    '{REQ_RAW_WR, 8'd0,   8'd1,   8'd0,   8'd0,   8'd1,   1, ST_OK},
    '{REQ_CHECK,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1, ST_INVALID}, // bad type byte
    '{REQ_RAW_WR, 8'd0,   8'd1,   8'd0,   8'd0,   8'd0,   1, ST_OK},
    '{REQ_RAW_WR, 8'd0,   8'd1,   8'd0,   8'd1,   8'd0,   1, ST_OK},
    '{REQ_CHECK,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1, ST_INVALID}, // zero count
    '{REQ_RAW_WR, 8'd0,   8'd1,   8'd0,   8'd1,   8'd2,   1, ST_OK}
  };

  initial begin
    req_t r;
    int   tags[$], lens[$];
    int   ops, pick, cfg_sel;
    for (int i = 0; i < MEM_BYTES; i++) img_mem[i] = '0;
    err_flag = 0;
    max_tag = HVT_RESET;
    n_err = 0;
    n_items = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // fill the store: count 0 first so no walk follows records into unwritten bytes
    raw_wr(1, 0);
    raw_wr(0, 0);
    for (int a = 2; a < MEM_BYTES; a++) raw_wr(a, $urandom_range(0, 255));
    // known image for the directed rows
    raw_wr(2, 5); raw_wr(3, 3); raw_wr(4, 8'h11); raw_wr(5, 8'h22); raw_wr(6, 8'h33);
    raw_wr(7, 250); raw_wr(8, 1); raw_wr(9, 8'h44);
    raw_wr(1, 2);

    foreach (dir_tab[i]) begin
      r = '{req: dir_tab[i].req, addr: dir_tab[i].addr, tag: dir_tab[i].tag,
            len: dir_tab[i].len, off: dir_tab[i].off, data: dir_tab[i].data};
      issue(r, dir_tab[i].has_st, dir_tab[i].st);
    end

    // random phases: build an image, then hammer it with record requests
    while (n_items < ITEM_GOAL) begin
      if (n_items % 6 < 1 || $urandom_range(0, 4) == 0) begin
        cfg_sel = $urandom_range(0, 4);
        set_max_tag(cfg_sel == 0 ? 8'd0 : cfg_sel == 1 ? 8'd254 :
                    cfg_sel == 2 ? HVT_RESET : 8'($urandom_range(0, 254)));
      end
      build_image(tags, lens);
      ops = $urandom_range(10, 40);
      for (int j = 0; j < ops; j++) begin
        r.req = 3'($urandom_range(REQ_GET, REQ_CHECK));
        if ($urandom_range(0, 9) == 0) r.req = 3'($urandom_range(REQ_RAW_WR, REQ_RAW_RD));
        r.addr = 8'($urandom_range(0, 255));
        r.data = 8'($urandom_range(0, 255));
        if (tags.size() != 0 && $urandom_range(0, 4) != 0) begin
          pick = $urandom_range(0, tags.size() - 1);
          r.tag = tags[pick];
          r.len = lens[pick];
        end else begin
          r.tag = ($urandom_range(0, 9) == 0) ? DELETED_TAG : 8'($urandom_range(0, 254));
          r.len = 8'($urandom_range(1, 250));
        end
        if ($urandom_range(0, 5) == 0) r.off = 8'($urandom_range(0, 249));
        else r.off = 8'($urandom_range(0, r.len - 1));
        // keep raw writes off the type and count bytes mostly, so the image stays walkable
        if (r.req == REQ_RAW_WR && r.addr < 2 && $urandom_range(0, 3) != 0) r.addr = 8'd2;
        issue(r);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (n_err == 0 && resp_q.size() == 0) begin
      $display("PASS tlv_record_store_engine_unit");
    end else begin
      $display("FAIL tlv_record_store_engine_unit");
    end
    $finish;
  end
endmodule
